// ----- design/sentinel_frame_receiver_defines.svh -----
// Assertion macros used by the checker file of the frame receiver.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef SENTINEL_FRAME_RECEIVER_DEFINES_SVH
`define SENTINEL_FRAME_RECEIVER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SFR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SFR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/sfr_pkg.sv -----
// Types, constants and register codes of the sentinel frame receiver.
// No dependencies; the other design files except the macro header use this package.
package sfr_pkg;

  localparam int BUFFER_DEPTH = 256;
  localparam int ADDR_W       = 8;
  localparam int BYTE_W       = 8;
  localparam int CMD_W        = 2;
  localparam int WAKE_W       = 3;
  localparam int IDLE_W       = 16;
  localparam int MASK_W       = 4;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;

  // Highest address the buffer allows, clipped to the address width.
  localparam int TOP_LIMIT_I  = (BUFFER_DEPTH - 1 > (1 << ADDR_W) - 1) ?
                                ((1 << ADDR_W) - 1) : (BUFFER_DEPTH - 1);
  localparam logic [ADDR_W-1:0] TOP_LIMIT = ADDR_W'(TOP_LIMIT_I);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_START_BYTE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END_BYTE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_INDEX   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_RELOAD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WAKE_MASK   = 3'd4;

  typedef enum logic [CMD_W-1:0] {
    CMD_BYTE  = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_ERROR = 2'd2
  } cmd_t;

  typedef struct packed {
    logic [BYTE_W-1:0] start_byte;
    logic [BYTE_W-1:0] end_byte;
    logic [ADDR_W-1:0] max_index;
    logic [IDLE_W-1:0] idle_reload;
    logic [MASK_W-1:0] wake_mask;
  } cfg_t;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [BYTE_W-1:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic              write_enable;
    logic [ADDR_W-1:0] write_addr;
    logic [BYTE_W-1:0] write_data;
    logic [WAKE_W-1:0] wake_flags;
    logic [ADDR_W-1:0] frame_length;
    logic [BYTE_W-1:0] error_total;
  } result_t;

endpackage

// ----- design/sfr_item_if.sv -----
// Input channel of the frame receiver: one received byte, tick or error per beat.
// Depends on sfr_pkg for field widths.
interface sfr_item_if;
  logic                        valid;
  logic                        ready;
  logic [sfr_pkg::CMD_W-1:0]   command;
  logic [sfr_pkg::BYTE_W-1:0]  rx_byte;

  modport source (output valid, output command, output rx_byte, input ready);
  modport sink   (input valid, input command, input rx_byte, output ready);
endinterface

// ----- design/sfr_result_if.sv -----
// Output channel of the frame receiver: one result per accepted input beat.
// Depends on sfr_pkg for field widths.
interface sfr_result_if;
  logic                        valid;
  logic                        ready;
  logic                        write_enable;
  logic [sfr_pkg::ADDR_W-1:0]  write_addr;
  logic [sfr_pkg::BYTE_W-1:0]  write_data;
  logic [sfr_pkg::WAKE_W-1:0]  wake_flags;
  logic [sfr_pkg::ADDR_W-1:0]  frame_length;
  logic [sfr_pkg::BYTE_W-1:0]  error_total;

  modport source (output valid, output write_enable, output write_addr, output write_data,
                  output wake_flags, output frame_length, output error_total, input ready);
  modport sink   (input valid, input write_enable, input write_addr, input write_data,
                  input wake_flags, input frame_length, input error_total, output ready);
endinterface

// ----- design/sentinel_frame_receiver.sv -----
// Sentinel frame receiver: turns received bytes, timer ticks and error events
// into buffer write commands, wakeup flags, the last frame length and an error
// count. Each accepted input beat yields exactly one result beat, through the input
// register, the engine's state update and the result register; one beat per cycle
// is taken while the result sink is ready. The user writes configuration through
// cfg_we, cfg_index and cfg_data only while idle; the block does not enforce this.
// Depends on sfr_pkg, sfr_item_if, sfr_result_if, sfr_cfg_regs and sfr_engine.
module sentinel_frame_receiver (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [sfr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sfr_pkg::CFG_DATA_W-1:0]   cfg_data,
  sfr_item_if.sink                         items,
  sfr_result_if.source                     results
);
  import sfr_pkg::*;

  cfg_t    cfg;
  item_t   stage_item;
  logic    stage_valid;
  result_t engine_result;
  result_t out_result;
  logic    out_valid;
  logic    advance;

  // The staged beat moves into the result register whenever that slot frees up.
  // No input beat is taken while reset is held, since ready is held low during reset.
  assign advance     = stage_valid && (!out_valid || results.ready);
  assign items.ready = !rst && (!stage_valid || advance);

  sfr_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sfr_engine u_engine (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .step   (advance),
    .item   (stage_item),
    .result (engine_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (items.ready) begin
        stage_valid <= items.valid;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (items.valid && items.ready) begin
      stage_item.command <= items.command;
      stage_item.rx_byte <= items.rx_byte;
    end
    if (advance) begin
      out_result <= engine_result;
    end
  end

  assign results.valid        = out_valid;
  assign results.write_enable = out_result.write_enable;
  assign results.write_addr   = out_result.write_addr;
  assign results.write_data   = out_result.write_data;
  assign results.wake_flags   = out_result.wake_flags;
  assign results.frame_length = out_result.frame_length;
  assign results.error_total  = out_result.error_total;
endmodule

// ----- design/sfr_cfg_regs.sv -----
// Configuration register file of the frame receiver.
// Depends on sfr_pkg for the register indexes and the cfg_t layout.
module sfr_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [sfr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sfr_pkg::CFG_DATA_W-1:0]   cfg_data,
  output sfr_pkg::cfg_t                    cfg
);
  import sfr_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_byte  <= '0;
      cfg.end_byte    <= '0;
      cfg.max_index   <= '1;
      cfg.idle_reload <= '0;
      cfg.wake_mask   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_START_BYTE:  cfg.start_byte  <= cfg_data[BYTE_W-1:0];
        REG_END_BYTE:    cfg.end_byte    <= cfg_data[BYTE_W-1:0];
        REG_MAX_INDEX:   cfg.max_index   <= cfg_data[ADDR_W-1:0];
        REG_IDLE_RELOAD: cfg.idle_reload <= cfg_data[IDLE_W-1:0];
        REG_WAKE_MASK:   cfg.wake_mask   <= cfg_data[MASK_W-1:0];
        default: ;
      endcase
    end
  end
endmodule

// ----- design/sfr_engine.sv -----
// Receive state of the frame receiver and the single-pass update for one beat.
// Depends on sfr_pkg; the state advances only when step is high.
module sfr_engine (
  input  logic                 clk,
  input  logic                 rst,
  input  sfr_pkg::cfg_t        cfg,
  input  logic                 step,
  input  sfr_pkg::item_t       item,
  output sfr_pkg::result_t     result
);
  import sfr_pkg::*;

  logic [ADDR_W-1:0] write_index, write_index_next;
  logic [IDLE_W-1:0] idle_count, idle_count_next;
  logic              start_seen, start_seen_next;
  logic              end_seen, end_seen_next;
  logic [ADDR_W-1:0] last_length, last_length_next;
  logic [BYTE_W-1:0] error_count, error_count_next;

  logic [ADDR_W-1:0] top;
  logic              plain;
  logic [ADDR_W:0]   index_inc;
  logic              wrap;
  logic [IDLE_W-1:0] idle_dec;

  assign top       = (cfg.max_index < TOP_LIMIT) ? cfg.max_index : TOP_LIMIT;
  assign plain     = (cfg.start_byte == '0) && (cfg.end_byte == '0);
  assign index_inc = {1'b0, write_index} + (ADDR_W+1)'(1);
  assign wrap      = index_inc > {1'b0, top};
  assign idle_dec  = idle_count - IDLE_W'(1);

  always_comb begin
    write_index_next    = write_index;
    idle_count_next     = idle_count;
    start_seen_next     = start_seen;
    end_seen_next       = end_seen;
    last_length_next    = last_length;
    error_count_next    = error_count;
    result.write_enable = 1'b0;
    result.write_addr   = '0;
    result.write_data   = '0;
    result.wake_flags   = '0;

    case (item.command)
      CMD_BYTE: begin
        result.write_enable = 1'b1;
        result.write_data   = item.rx_byte;
        idle_count_next     = cfg.idle_reload;
        if (plain) begin
          result.write_addr    = write_index;
          result.wake_flags[0] = cfg.wake_mask[0];
          if (wrap) begin
            write_index_next = '0;
            if (cfg.wake_mask[1]) begin
              result.wake_flags[0] = 1'b1;
            end
          end else begin
            write_index_next = index_inc[ADDR_W-1:0];
          end
        end else if (item.rx_byte == cfg.start_byte && !start_seen) begin
          // The start byte always lands at address zero, and only once per frame.
          start_seen_next  = 1'b1;
          result.write_addr = '0;
          write_index_next = ADDR_W'(1);
        end else if (item.rx_byte == cfg.end_byte && start_seen) begin
          result.write_addr = write_index;
          end_seen_next     = 1'b1;
          if (cfg.wake_mask[1]) begin
            last_length_next     = write_index;
            write_index_next     = '0;
            start_seen_next      = 1'b0;
            end_seen_next        = 1'b0;
            result.wake_flags[0] = 1'b1;
          end
        end else begin
          result.write_addr = write_index;
          if (wrap) begin
            write_index_next = '0;
            start_seen_next  = 1'b0;
            end_seen_next    = 1'b0;
          end else begin
            write_index_next = index_inc[ADDR_W-1:0];
          end
        end
      end
      CMD_TICK: begin
        // The idle timer only runs while a partial run is pending in the buffer.
        if (idle_count != '0 && write_index != '0) begin
          if (idle_dec == '0) begin
            idle_count_next  = cfg.idle_reload;
            last_length_next = write_index;
            write_index_next = '0;
            if (cfg.wake_mask[2]) begin
              result.wake_flags[1:0] = 2'b11;
            end
          end else begin
            idle_count_next = idle_dec;
          end
        end
      end
      CMD_ERROR: begin
        error_count_next     = error_count + BYTE_W'(1);
        result.wake_flags[2] = cfg.wake_mask[3];
      end
      default: ;
    endcase

    result.frame_length = last_length_next;
    result.error_total  = error_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_index <= '0;
      idle_count  <= '0;
      start_seen  <= 1'b0;
      end_seen    <= 1'b0;
      last_length <= '0;
      error_count <= '0;
    end else if (step) begin
      write_index <= write_index_next;
      idle_count  <= idle_count_next;
      start_seen  <= start_seen_next;
      end_seen    <= end_seen_next;
      last_length <= last_length_next;
      error_count <= error_count_next;
    end
  end
endmodule

// ----- design/sfr_checker.sv -----
// Port-level checks of the frame receiver's result channel, bound to the top level.
// Depends on sfr_pkg and the assertion macros in sentinel_frame_receiver_defines.svh.
`include "sentinel_frame_receiver_defines.svh"

module sfr_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         write_enable,
  input logic [sfr_pkg::ADDR_W-1:0]   write_addr,
  input logic [sfr_pkg::BYTE_W-1:0]   write_data,
  input logic [sfr_pkg::WAKE_W-1:0]   wake_flags
);
  import sfr_pkg::*;

  `SFR_ASSERT_NXT(a_stall_holds, out_valid && !out_ready, out_valid && $stable(write_addr) && $stable(write_data), "result beat changed while stalled")
  `SFR_ASSERT_IMP(a_idle_write_zero, out_valid && !write_enable, write_addr == '0 && write_data == '0, "address or data set without a write")
  `SFR_ASSERT_IMP(a_byte_wake_only_rx, out_valid && write_enable, wake_flags[2:1] == 2'b00, "byte beat raised timeout or error wakeup")
  `SFR_ASSERT_IMP(a_timeout_with_rx, out_valid && wake_flags[1], wake_flags[0] && !wake_flags[2], "timeout wakeup without rx wakeup")
endmodule

bind sentinel_frame_receiver sfr_checker u_sfr_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (results.valid),
  .out_ready    (results.ready),
  .write_enable (results.write_enable),
  .write_addr   (results.write_addr),
  .write_data   (results.write_data),
  .wake_flags   (results.wake_flags)
);

// ----- bench/sfr_tb_pkg.sv -----
// Scoreboard of the sentinel frame receiver bench: predicts the result beat of every
// accepted input beat and checks the result beats in order against those predictions.
// Depends on sfr_pkg for the field types, command codes and register indexes.
package sfr_tb_pkg;
  import sfr_pkg::*;

  localparam logic [CMD_W-1:0]     CMD_UNKNOWN  = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE    = 3'd5;
  localparam int                   REPORT_LIMIT = 10;

  class rx_scoreboard;
    cfg_t              cfg;
    logic [ADDR_W-1:0] write_index;
    logic [IDLE_W-1:0] idle_count;
    logic              start_seen;
    logic              end_seen;
    logic [ADDR_W-1:0] last_length;
    logic [BYTE_W-1:0] error_count;
    result_t           owed_beats[$];
    int                failures;

    function new();
      cfg             = '0;
      cfg.max_index   = 8'hFF;
      write_index     = '0;
      idle_count      = '0;
      start_seen      = 1'b0;
      end_seen        = 1'b0;
      last_length     = '0;
      error_count     = '0;
      failures        = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_START_BYTE:  cfg.start_byte  = val[BYTE_W-1:0];
        REG_END_BYTE:    cfg.end_byte    = val[BYTE_W-1:0];
        REG_MAX_INDEX:   cfg.max_index   = val[ADDR_W-1:0];
        REG_IDLE_RELOAD: cfg.idle_reload = val[IDLE_W-1:0];
        REG_WAKE_MASK:   cfg.wake_mask   = val[MASK_W-1:0];
        default: ;
      endcase
    endfunction

    // Advances the receiver state by one input beat and returns the buffer write,
    // wakeups and counters that beat produces.
    function result_t rx_outcome(item_t it);
      result_t r;
      int      top;
      int      nxt;
      r   = '0;
      top = (cfg.max_index < BUFFER_DEPTH - 1) ? cfg.max_index : BUFFER_DEPTH - 1;
      case (it.command)
        CMD_BYTE: begin
          r.write_enable = 1'b1;
          r.write_data   = it.rx_byte;
          idle_count     = cfg.idle_reload;
          if (cfg.start_byte == '0 && cfg.end_byte == '0) begin
            r.write_addr = write_index;
            if (cfg.wake_mask[0]) r.wake_flags[0] = 1'b1;
            nxt = write_index + 1;
            if (nxt > top) begin
              nxt = 0;
              if (cfg.wake_mask[1]) r.wake_flags[0] = 1'b1;
            end
            write_index = ADDR_W'(nxt);
          end else if (it.rx_byte == cfg.start_byte && !start_seen) begin
            // The opening sentinel always lands at address zero, once per frame.
            start_seen   = 1'b1;
            r.write_addr = '0;
            write_index  = ADDR_W'(1);
          end else if (it.rx_byte == cfg.end_byte && start_seen) begin
            r.write_addr = write_index;
            end_seen     = 1'b1;
            if (cfg.wake_mask[1]) begin
              last_length     = write_index;
              write_index     = '0;
              start_seen      = 1'b0;
              end_seen        = 1'b0;
              r.wake_flags[0] = 1'b1;
            end
          end else begin
            r.write_addr = write_index;
            nxt = write_index + 1;
            if (nxt > top) begin
              nxt        = 0;
              start_seen = 1'b0;
              end_seen   = 1'b0;
            end
            write_index = ADDR_W'(nxt);
          end
        end
        CMD_TICK: begin
          if (idle_count != '0 && write_index != '0) begin
            idle_count = idle_count - 1'b1;
            if (idle_count == '0) begin
              idle_count  = cfg.idle_reload;
              last_length = write_index;
              write_index = '0;
              if (cfg.wake_mask[2]) r.wake_flags[1:0] = 2'b11;
            end
          end
        end
        CMD_ERROR: begin
          error_count = error_count + 1'b1;
          if (cfg.wake_mask[3]) r.wake_flags[2] = 1'b1;
        end
        default: ;
      endcase
      r.frame_length = last_length;
      r.error_total  = error_count;
      return r;
    endfunction

    function void note_item(item_t it);
      owed_beats.push_back(rx_outcome(it));
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (owed_beats.size() == 0) begin
        if (failures < REPORT_LIMIT)
          $display("result beat with nothing owed: we=%0d addr=%0d data=%0d wake=%0d",
                   got.write_enable, got.write_addr, got.write_data, got.wake_flags);
        failures++;
        return;
      end
      want = owed_beats.pop_front();
      if (got.write_enable !== want.write_enable || got.write_addr !== want.write_addr ||
          got.write_data !== want.write_data || got.wake_flags !== want.wake_flags ||
          got.frame_length !== want.frame_length || got.error_total !== want.error_total) begin
        if (failures < REPORT_LIMIT) begin
          $display("result mismatch: expected we=%0d addr=%0d data=%0d wake=%0d len=%0d err=%0d",
                   want.write_enable, want.write_addr, want.write_data, want.wake_flags,
                   want.frame_length, want.error_total);
          $display("                 actual   we=%0d addr=%0d data=%0d wake=%0d len=%0d err=%0d",
                   got.write_enable, got.write_addr, got.write_data, got.wake_flags,
                   got.frame_length, got.error_total);
        end
        failures++;
      end
    endfunction

    function int pending();
      return owed_beats.size();
    endfunction
  endclass

endpackage

// ----- bench/sentinel_frame_receiver_tb.sv -----
// Top of the sentinel frame receiver bench: clock, reset, register writes, bursty
// input traffic and a stalling result sink, checked beat by beat by rx_scoreboard.
// Depends on sfr_pkg, sfr_tb_pkg, the two channel interfaces and the receiver itself.
module sentinel_frame_receiver_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sfr_pkg::*;
  import sfr_tb_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int LONG_HOLD   = 120;
  localparam int TAIL_CYCLES = 8;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 200;

  typedef enum int {SINK_OPEN, SINK_COIN, SINK_MOSTLY, SINK_PATTERN} sink_mode_e;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  bit                    hold_off_req;

  sfr_item_if   items_if ();
  sfr_result_if results_if ();

  rx_scoreboard sb;
  item_t        stim_q[$];

  sentinel_frame_receiver u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .items     (items_if),
    .results   (results_if)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  function automatic void push_item(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] b);
    item_t it;
    it.command = cmd;
    it.rx_byte = b;
    stim_q.push_back(it);
  endfunction

  task automatic send_item(input item_t it);
    items_if.valid   <= 1'b1;
    items_if.command <= it.command;
    items_if.rx_byte <= it.rx_byte;
    do @(posedge clk); while (items_if.ready !== 1'b1);
  endtask

  task automatic idle_input(input int n);
    items_if.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Sends the queued beats in bursts of random length, mostly with random gaps between them.
  task automatic play_stimulus();
    int burst;
    while (stim_q.size() > 0) begin
      burst = $urandom_range(1, 40);
      while (burst > 0 && stim_q.size() > 0) begin
        send_item(stim_q.pop_front());
        burst--;
      end
      if ($urandom_range(0, 3) != 0) idle_input($urandom_range(1, 12));
    end
    idle_input(1);
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [BYTE_W-1:0] pick_sentinel();
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic random_config();
    logic [BYTE_W-1:0] s;
    logic [BYTE_W-1:0] e;
    logic [ADDR_W-1:0] m;
    logic [IDLE_W-1:0] r;
    logic [MASK_W-1:0] w;
    s = pick_sentinel();
    e = pick_sentinel();
    if ($urandom_range(0, 3) == 0) begin
      s = '0;
      e = '0;
    end
    case ($urandom_range(0, 3))
      0:       m = 8'd0;
      1:       m = 8'hFF;
      2:       m = 8'($urandom_range(1, 12));
      default: m = 8'($urandom_range(0, 255));
    endcase
    case ($urandom_range(0, 4))
      0:       r = 16'd0;
      1:       r = 16'd1;
      2:       r = 16'hFFFF;
      default: r = 16'($urandom_range(2, 10));
    endcase
    w = ($urandom_range(0, 3) == 0) ? 4'hF : 4'($urandom_range(0, 15));
    // Upper data bits beyond a register's width are filled with noise where it is narrower.
    set_reg(REG_START_BYTE, {8'($urandom_range(0, 255)), s});
    set_reg(REG_END_BYTE, {8'($urandom_range(0, 255)), e});
    set_reg(REG_MAX_INDEX, {8'($urandom_range(0, 255)), m});
    set_reg(REG_IDLE_RELOAD, r);
    set_reg(REG_WAKE_MASK, {12'($urandom_range(0, 4095)), w});
    if ($urandom_range(0, 2) == 0)
      set_reg(REG_SPARE + 3'($urandom_range(0, 2)), 16'($urandom_range(0, 65535)));
  endtask

  // Mostly frames with random content, some left open and followed by ticks, plus tick runs, error bursts and noise.
  task automatic build_random_items(input int n);
    int                pick;
    int                len;
    int                top;
    int                span;
    logic [BYTE_W-1:0] b;
    top = (sb.cfg.max_index < BUFFER_DEPTH - 1) ? sb.cfg.max_index : BUFFER_DEPTH - 1;
    while (stim_q.size() < n) begin
      pick = $urandom_range(0, 19);
      span = (sb.cfg.idle_reload <= 12) ? sb.cfg.idle_reload + 1 : $urandom_range(1, 8);
      if (pick < 11) begin
        push_item(CMD_BYTE, sb.cfg.start_byte);
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, top + 2) : $urandom_range(0, 10);
        repeat (len) begin
          b = 8'($urandom_range(0, 255));
          if ((b == sb.cfg.start_byte || b == sb.cfg.end_byte) && $urandom_range(0, 3) != 0)
            b = b + 8'd1;
          push_item(CMD_BYTE, b);
          if ($urandom_range(0, 5) == 0) push_item(CMD_TICK, 8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 4) != 0) push_item(CMD_BYTE, sb.cfg.end_byte);
        else repeat (span) push_item(CMD_TICK, 8'($urandom_range(0, 255)));
      end else if (pick < 14) begin
        repeat ($urandom_range(1, span)) push_item(CMD_TICK, 8'($urandom_range(0, 255)));
      end else if (pick < 16) begin
        repeat ($urandom_range(1, 30)) push_item(CMD_ERROR, 8'($urandom_range(0, 255)));
      end else if (pick < 19) begin
        repeat ($urandom_range(1, 6))
          push_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end else begin
        push_item(CMD_UNKNOWN, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin : stimulus
    int phase;
    sb = new();
    rst              <= 1'b1;
    cfg_we           <= 1'b0;
    cfg_index        <= '0;
    cfg_data         <= '0;
    items_if.valid   <= 1'b0;
    items_if.command <= CMD_BYTE;
    items_if.rx_byte <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Plain mode with a four-entry buffer: wrap, idle expiry, error, unknown command.
    set_reg(REG_MAX_INDEX, 16'd3);
    set_reg(REG_IDLE_RELOAD, 16'd2);
    set_reg(REG_WAKE_MASK, 16'h000F);
    push_item(CMD_BYTE, 8'h00);
    push_item(CMD_BYTE, 8'hFF);
    push_item(CMD_BYTE, 8'hA5);
    push_item(CMD_BYTE, 8'h5A);
    push_item(CMD_BYTE, 8'h3C);
    push_item(CMD_TICK, 8'h00);
    push_item(CMD_TICK, 8'hFF);
    push_item(CMD_TICK, 8'h00);
    push_item(CMD_ERROR, 8'h00);
    push_item(CMD_UNKNOWN, 8'hFF);
    play_stimulus();
    wait_drained();

    // Sentinel mode: end byte outside a frame, a repeated start byte inside one, close.
    set_reg(REG_START_BYTE, 16'h007E);
    set_reg(REG_END_BYTE, 16'h0081);
    set_reg(REG_MAX_INDEX, 16'h00FF);
    push_item(CMD_BYTE, 8'h81);
    push_item(CMD_BYTE, 8'h7E);
    push_item(CMD_BYTE, 8'h11);
    push_item(CMD_BYTE, 8'h7E);
    push_item(CMD_BYTE, 8'h81);
    push_item(CMD_ERROR, 8'h00);
    play_stimulus();
    wait_drained();

    // Without the frame-end wake the frame stays open and end bytes overwrite one address.
    set_reg(REG_WAKE_MASK, 16'h0001);
    push_item(CMD_BYTE, 8'h7E);
    push_item(CMD_BYTE, 8'h22);
    push_item(CMD_BYTE, 8'h81);
    push_item(CMD_BYTE, 8'h81);
    push_item(CMD_BYTE, 8'h33);
    play_stimulus();
    wait_drained();

    for (phase = 0; phase < PHASES; phase++) begin
      random_config();
      build_random_items(PHASE_ITEMS);
      if (phase == 3) hold_off_req = 1'b1;
      play_stimulus();
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("sentinel_frame_receiver_tb passed");
    end else begin
      $display("sentinel_frame_receiver_tb failed");
    end
    $finish;
  end

  // The sink changes its stall behavior after each random span, and once holds off
  // long enough for the block to back up into its input.
  initial begin : result_sink
    sink_mode_e mode;
    int         span;
    int         hold;
    int         beat_phase;
    mode       = SINK_OPEN;
    span       = 0;
    hold       = 0;
    beat_phase = 0;
    results_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      beat_phase++;
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold         = LONG_HOLD;
      end
      if (hold > 0) begin
        hold--;
        results_if.ready <= 1'b0;
      end else begin
        if (span == 0) begin
          mode = sink_mode_e'($urandom_range(0, 3));
          span = $urandom_range(16, 256);
        end
        span--;
        case (mode)
          SINK_OPEN:   results_if.ready <= 1'b1;
          SINK_COIN:   results_if.ready <= 1'($urandom_range(0, 1));
          SINK_MOSTLY: results_if.ready <= ($urandom_range(0, 7) != 0);
          default:     results_if.ready <= ((beat_phase % 7) < 3);
        endcase
      end
    end
  end

  always @(posedge clk) begin : beat_monitor
    item_t   it;
    result_t got;
    if (!rst) begin
      if (items_if.valid === 1'b1 && items_if.ready === 1'b1) begin
        it.command = items_if.command;
        it.rx_byte = items_if.rx_byte;
        sb.note_item(it);
      end
      if (results_if.valid === 1'b1 && results_if.ready === 1'b1) begin
        got.write_enable = results_if.write_enable;
        got.write_addr   = results_if.write_addr;
        got.write_data   = results_if.write_data;
        got.wake_flags   = results_if.wake_flags;
        got.frame_length = results_if.frame_length;
        got.error_total  = results_if.error_total;
        sb.check_result(got);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || cfg_we || (items_if.valid && items_if.ready) ||
          (results_if.valid && results_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("sentinel_frame_receiver_tb failed");
    $finish;
  end

endmodule
